FILE: src/dclk_pkg.sv
package dclk_pkg;

    // display geometry and counter widths
    localparam int NUM_DIGITS = 6;
    localparam int TPS_W      = 16;
    localparam int POS_W      = 3;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int SEG_W      = 7;

    // reset values
    localparam logic [TPS_W-1:0]  TPS_RESET  = 16'd900;
    localparam logic [HOUR_W-1:0] HOUR_RESET = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_RESET  = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_RESET  = 6'd50;

    // wrap limits
    localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;

    // seven-segment font, bit 0 is segment a
    localparam logic [SEG_W-1:0] SEG_FONT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };
    localparam logic [SEG_W-1:0] SEG_ZERO = 7'h3F;

    // key codes, one per scan position
    typedef enum logic [POS_W-1:0] {
        KEY_ENTER  = 3'd0,
        KEY_ESCAPE = 3'd1,
        KEY_RIGHT  = 3'd2,
        KEY_UP     = 3'd3,
        KEY_DOWN   = 3'd4,
        KEY_LEFT   = 3'd5
    } t_key;

    // field under the edit cursor
    typedef enum logic [1:0] {
        FIELD_SEC  = 2'd0,
        FIELD_MIN  = 2'd1,
        FIELD_HOUR = 2'd2
    } t_field;

    // one result item
    typedef struct packed {
        logic [NUM_DIGITS-1:0] digit_select;
        logic [SEG_W-1:0]      segments;
        logic                  led;
        logic                  editing;
        logic [HOUR_W-1:0]     hours;
        logic [MIN_W-1:0]      minutes;
        logic [SEC_W-1:0]      seconds;
    } t_result;

    // tens digit of a value below 60
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd50)      t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    // units digit of a value below 60
    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] tens10;
        logic [5:0] u;
        tens10 = {2'b00, tens_of(v)} * 6'd10;
        u      = v - tens10;
        return u[3:0];
    endfunction

endpackage

FILE: src/digital_clock_keypad_set_top.sv
// Keypad-settable hh:mm:ss clock for a six-digit multiplexed seven-segment
// display. Every accepted input transfer is one scan tick: the scan moves to
// the next digit, the pattern for that digit, built from the time before this
// tick, is shown, the keypad return line is checked for the key at that position,
// and the time advances once ticks_per_second ticks make a second (not while
// editing). One tick is taken per clock cycle while o_in_ready is high; its
// result is registered in the output register, or in a skid entry holding one
// more result when the consumer stalls. The user must write ticks_per_second
// through the configuration port only while idle; the block does not enforce it.
module digital_clock_keypad_set_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [dclk_pkg::TPS_W-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_key_line,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dclk_pkg::NUM_DIGITS-1:0] o_digit_select,
    output logic [dclk_pkg::SEG_W-1:0]      o_segments,
    output logic                            o_led,
    output logic                            o_editing,
    output logic [dclk_pkg::HOUR_W-1:0]     o_hours,
    output logic [dclk_pkg::MIN_W-1:0]      o_minutes,
    output logic [dclk_pkg::SEC_W-1:0]      o_seconds
);

    // clock state
    logic [dclk_pkg::TPS_W-1:0]  r_ticks_per_second;
    logic [dclk_pkg::TPS_W-1:0]  r_tick_count, n_tick_count;
    logic [dclk_pkg::POS_W-1:0]  r_scan_pos, n_scan_pos;
    logic [dclk_pkg::POS_W-1:0]  r_held_key, n_held_key;
    logic                        r_edit, n_edit;
    dclk_pkg::t_field            r_cursor, n_cursor;
    logic                        r_led, n_led;
    logic [dclk_pkg::HOUR_W-1:0] r_hour, n_hour;
    logic [dclk_pkg::MIN_W-1:0]  r_min, n_min;
    logic [dclk_pkg::SEC_W-1:0]  r_sec, n_sec;
    logic                        r_started;

    // output stages
    dclk_pkg::t_result r_out, r_skid, n_result;
    logic              r_out_valid, r_skid_valid;

    logic                        in_xfer;
    logic                        out_xfer;
    logic [dclk_pkg::TPS_W-1:0]  tick_inc;
    logic                        second_due;
    logic [dclk_pkg::HOUR_W-1:0] hour_k;
    logic [dclk_pkg::MIN_W-1:0]  min_k;
    logic [dclk_pkg::SEC_W-1:0]  sec_k;
    logic [3:0]                  shown_digit;
    logic [dclk_pkg::SEG_W-1:0]  shown;

    assign o_in_ready = !r_skid_valid;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    // scan position and tick counter
    always_comb begin
        n_scan_pos = (r_scan_pos >= dclk_pkg::POS_W'(dclk_pkg::NUM_DIGITS - 1))
                   ? '0 : r_scan_pos + 1'b1;
        tick_inc   = r_tick_count + 1'b1;
        second_due = (tick_inc >= r_ticks_per_second);
        n_tick_count = second_due ? tick_inc - r_ticks_per_second : tick_inc;
    end

    // pattern shown for the new position, built from the time before this tick
    always_comb begin
        case (n_scan_pos)
            3'd0:    shown_digit = dclk_pkg::units_of(r_sec);
            3'd1:    shown_digit = dclk_pkg::tens_of(r_sec);
            3'd2:    shown_digit = dclk_pkg::units_of(r_min);
            3'd3:    shown_digit = dclk_pkg::tens_of(r_min);
            3'd4:    shown_digit = dclk_pkg::units_of({1'b0, r_hour});
            3'd5:    shown_digit = dclk_pkg::tens_of({1'b0, r_hour});
            default: shown_digit = '0;
        endcase
        shown = r_started ? dclk_pkg::SEG_FONT[shown_digit] : dclk_pkg::SEG_ZERO;
    end

    // key press and release, then key action
    always_comb begin
        n_held_key = r_held_key;
        n_edit     = r_edit;
        n_cursor   = r_cursor;
        n_led      = r_led;
        hour_k     = r_hour;
        min_k      = r_min;
        sec_k      = r_sec;
        if (r_held_key == n_scan_pos + 1'b1 && !i_key_line) begin
            n_held_key = '0;
        end else if (r_held_key == '0 && i_key_line) begin
            n_held_key = n_scan_pos + 1'b1;
            case (dclk_pkg::t_key'(n_scan_pos))
                dclk_pkg::KEY_ENTER: begin
                    n_led  = 1'b1;
                    n_edit = 1'b0;
                end
                dclk_pkg::KEY_ESCAPE: begin
                    n_led    = !r_led;
                    n_edit   = 1'b1;
                    n_cursor = dclk_pkg::FIELD_SEC;
                end
                dclk_pkg::KEY_RIGHT: begin
                    if (r_edit) begin
                        n_led = !r_led;
                        case (r_cursor)
                            dclk_pkg::FIELD_SEC: n_cursor = dclk_pkg::FIELD_SEC;
                            dclk_pkg::FIELD_MIN: n_cursor = dclk_pkg::FIELD_SEC;
                            default:             n_cursor = dclk_pkg::FIELD_MIN;
                        endcase
                    end
                end
                dclk_pkg::KEY_LEFT: begin
                    if (r_edit) begin
                        n_led = !r_led;
                        case (r_cursor)
                            dclk_pkg::FIELD_SEC: n_cursor = dclk_pkg::FIELD_MIN;
                            dclk_pkg::FIELD_MIN: n_cursor = dclk_pkg::FIELD_HOUR;
                            default:             n_cursor = r_cursor;
                        endcase
                    end
                end
                dclk_pkg::KEY_UP: begin
                    if (r_edit) begin
                        n_led = !r_led;
                        case (r_cursor)
                            dclk_pkg::FIELD_SEC:
                                sec_k = (r_sec >= dclk_pkg::SEC_LAST) ? '0 : r_sec + 1'b1;
                            dclk_pkg::FIELD_MIN:
                                min_k = (r_min >= dclk_pkg::MIN_LAST) ? '0 : r_min + 1'b1;
                            default:
                                hour_k = (r_hour >= dclk_pkg::HOUR_LAST) ? '0 : r_hour + 1'b1;
                        endcase
                    end
                end
                dclk_pkg::KEY_DOWN: begin
                    if (r_edit) begin
                        n_led = !r_led;
                        case (r_cursor)
                            dclk_pkg::FIELD_SEC:
                                sec_k = (r_sec == '0) ? dclk_pkg::SEC_LAST : r_sec - 1'b1;
                            dclk_pkg::FIELD_MIN:
                                min_k = (r_min == '0) ? dclk_pkg::MIN_LAST : r_min - 1'b1;
                            default:
                                hour_k = (r_hour == '0) ? dclk_pkg::HOUR_LAST : r_hour - 1'b1;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // time advance with carry, frozen while editing
    always_comb begin
        n_hour = hour_k;
        n_min  = min_k;
        n_sec  = sec_k;
        if (second_due && !n_edit) begin
            if (sec_k >= dclk_pkg::SEC_LAST) begin
                n_sec = '0;
                if (min_k >= dclk_pkg::MIN_LAST) begin
                    n_min  = '0;
                    n_hour = (hour_k >= dclk_pkg::HOUR_LAST) ? '0 : hour_k + 1'b1;
                end else begin
                    n_min = min_k + 1'b1;
                end
            end else begin
                n_sec = sec_k + 1'b1;
            end
        end
    end

    // result of this tick
    always_comb begin
        n_result.digit_select = dclk_pkg::NUM_DIGITS'(1) << n_scan_pos;
        n_result.segments     = shown;
        n_result.led          = n_led;
        n_result.editing      = n_edit;
        n_result.hours        = n_hour;
        n_result.minutes      = n_min;
        n_result.seconds      = n_sec;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second <= dclk_pkg::TPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_ticks_per_second <= i_cfg_wr_data;
        end
    end

    // clock state update on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_scan_pos   <= '0;
            r_held_key   <= '0;
            r_edit       <= 1'b0;
            r_cursor     <= dclk_pkg::FIELD_SEC;
            r_led        <= 1'b1;
            r_hour       <= dclk_pkg::HOUR_RESET;
            r_min        <= dclk_pkg::MIN_RESET;
            r_sec        <= dclk_pkg::SEC_RESET;
            r_started    <= 1'b0;
        end else if (in_xfer) begin
            r_tick_count <= n_tick_count;
            r_scan_pos   <= n_scan_pos;
            r_held_key   <= n_held_key;
            r_edit       <= n_edit;
            r_cursor     <= n_cursor;
            r_led        <= n_led;
            r_hour       <= n_hour;
            r_min        <= n_min;
            r_sec        <= n_sec;
            r_started    <= 1'b1;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) begin
                r_out <= r_skid;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_digit_select = r_out.digit_select;
    assign o_segments     = r_out.segments;
    assign o_led          = r_out.led;
    assign o_editing      = r_out.editing;
    assign o_hours        = r_out.hours;
    assign o_minutes      = r_out.minutes;
    assign o_seconds      = r_out.seconds;

    // skid entry only ever sits behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // a transfer into a full, stalled output lands in the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("result lost on stalled output");

    // time stays in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hour <= dclk_pkg::HOUR_LAST) && (r_min <= dclk_pkg::MIN_LAST)
        && (r_sec <= dclk_pkg::SEC_LAST))
        else $error("time counter out of range");

    // scan stays on a real digit and the shown digit is one-hot
    a_scan_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($onehot(o_digit_select)
            && r_scan_pos < dclk_pkg::POS_W'(dclk_pkg::NUM_DIGITS)))
        else $error("scan position out of range");

    // time holds still while editing without a key change
    a_edit_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_edit && n_edit && r_held_key != '0) |=>
            (r_hour == $past(r_hour) && r_min == $past(r_min) && r_sec == $past(r_sec)))
        else $error("time advanced while editing");

endmodule
